// ===== design/scs_pkg.sv =====
// Package for the five-point cubic smoothing block.
// Holds the word types, the job passed from front to back, and the kernel tables.
// No dependencies.
package scs_pkg;

  // Sample format
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned WinLen      = 5;
  localparam int unsigned CntW        = 3;   // holds 0..WinLen

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [7:0]             coef_t;

  localparam sample_t SampleMin = {1'b1, {(SampleWidth-1){1'b0}}};
  localparam sample_t SampleMax = {1'b0, {(SampleWidth-1){1'b1}}};

  // Input and output words
  typedef struct packed {
    sample_t sample;
    logic    last_sample;
  } in_word_t;

  typedef struct packed {
    sample_t smoothed;
    logic    last_result;
  } out_word_t;

  // What a job asks the back end to produce
  typedef enum logic [2:0] {
    PlanShort,     // pass held samples through unchanged
    PlanStart,     // first, second and center kernels
    PlanStartEnd,  // all five kernels over one window
    PlanMid,       // center kernel only
    PlanMidEnd     // center, penultimate and final kernels
  } plan_e;

  typedef enum logic [2:0] {
    KFirst,
    KSecond,
    KMid,
    KPenult,
    KFinal,
    KPass
  } kern_e;

  typedef struct packed {
    sample_t [WinLen-1:0] win;   // index 0 is the oldest sample
    plan_e                plan;
    logic [CntW-1:0]      nres;  // number of results this job gives
    logic                 last;  // job closes the sequence
  } scs_job_t;

  // Kernel coefficients, index 0 applies to the oldest sample
  localparam coef_t [WinLen-1:0] CoefFirst  = {-8'sd1, 8'sd4, -8'sd6, 8'sd4, 8'sd69};
  localparam coef_t [WinLen-1:0] CoefSecond = {8'sd2, -8'sd8, 8'sd12, 8'sd27, 8'sd2};
  localparam coef_t [WinLen-1:0] CoefMid    = {-8'sd3, 8'sd12, 8'sd17, 8'sd12, -8'sd3};
  localparam coef_t [WinLen-1:0] CoefPenult = {8'sd2, 8'sd27, 8'sd12, -8'sd8, 8'sd2};
  localparam coef_t [WinLen-1:0] CoefFinal  = {8'sd69, 8'sd4, -8'sd6, 8'sd4, -8'sd1};
  localparam coef_t              CoefPass   = 8'sd35;  // identity scaled by the divisor

  // Base divisor; end kernels use twice this
  localparam int unsigned Div     = 35;
  localparam int unsigned HalfDiv = Div / 2;

endpackage

// ===== design/five_point_cubic_smoothing_top.sv =====
// Top level of the five-point cubic smoothing block.
// Instantiates scs_front, scs_queue and scs_back; depends on scs_pkg.
//
//   Channel | Direction | Handshake                 | Word
//   --------+-----------+---------------------------+-----------
//   in      | input     | in_valid_i / in_ready_o   | in_word_i
//   out     | output    | out_valid_o / out_ready_i | out_word_o
//
// Sustained rate is one sample a cycle while each sample gives one result and the output is not held back.
// A sample that opens a full window gives three or five results, one that closes a sequence
// gives three, or as many as the samples held if the window never filled; the back end works through a
// job's results one at a time, and the front keeps taking samples until the job queue (QueueDepth entries) is full.
// A job at the queue head reaches the output through the product, sum, rounding, quotient and output registers.
// Reset clears the window, count, queue and pipeline valids; a word held at the
// output while out_ready_i is low freezes the whole back pipeline.
module five_point_cubic_smoothing_top import scs_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  scs_job_t push_job, pop_job;

  // Window and planning
  scs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  // Job queue
  scs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // Kernel evaluation
  scs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== design/scs_front.sv =====
// Front end of the smoothing block: sample window, sequence count, job planning.
// Depends on scs_pkg.
module scs_front import scs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output scs_job_t job_o
);

  sample_t [WinLen-1:0] win_q, win_d, win_new;
  logic [CntW-1:0]      cnt_q, cnt_d, cnt_new;
  logic                 accept;
  logic                 need_push;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next window: fill while short, shift once full
  always_comb begin
    win_new = win_q;
    cnt_new = cnt_q;
    if (cnt_q < CntW'(WinLen)) begin
      win_new[cnt_q] = in_word_i.sample;
      cnt_new        = cnt_q + 1'b1;
    end else begin
      for (int i = 0; i < WinLen - 1; i++) begin
        win_new[i] = win_q[i+1];
      end
      win_new[WinLen-1] = in_word_i.sample;
    end
  end

  // Decide what results this sample causes
  always_comb begin
    need_push  = 1'b0;
    job_o.win  = win_new;
    job_o.plan = PlanMid;
    job_o.nres = CntW'(1);
    job_o.last = in_word_i.last_sample;
    if (cnt_q < CntW'(WinLen)) begin
      if (cnt_new == CntW'(WinLen)) begin
        need_push  = 1'b1;
        job_o.plan = in_word_i.last_sample ? PlanStartEnd : PlanStart;
        job_o.nres = in_word_i.last_sample ? CntW'(5) : CntW'(3);
      end else if (in_word_i.last_sample) begin
        need_push  = 1'b1;
        job_o.plan = PlanShort;
        job_o.nres = cnt_new;
      end
    end else begin
      need_push  = 1'b1;
      job_o.plan = in_word_i.last_sample ? PlanMidEnd : PlanMid;
      job_o.nres = in_word_i.last_sample ? CntW'(3) : CntW'(1);
    end
  end

  assign job_valid_o = in_valid_i && need_push;

  // Last sample clears the sequence
  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (in_word_i.last_sample) begin
        win_d = '0;
        cnt_d = '0;
      end else begin
        win_d = win_new;
        cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
    end else begin
      win_q <= win_d;
      cnt_q <= cnt_d;
    end
  end

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_word_i.last_sample |=> cnt_q == '0)
    else $error("sequence count not cleared after last sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(WinLen))
    else $error("sequence count beyond window length");

endmodule

// ===== design/scs_queue.sv =====
// Short job queue between the front and back ends of the smoothing block.
// Depends on scs_pkg.
module scs_queue import scs_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  scs_job_t push_job_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output scs_job_t pop_job_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned QCntW = $clog2(Depth + 1);

  scs_job_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]    cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = cnt_q != QCntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(Depth))
    else $error("queue fill count beyond depth");

endmodule

// ===== design/scs_back.sv =====
// Back end of the smoothing block: steps through each job's kernels and runs
// the multiply, sum, divide-round and saturate pipeline. Depends on scs_pkg.
module scs_back import scs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  scs_job_t  job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  // Datapath widths
  localparam int unsigned SumW   = SampleWidth + 8;       // products and kernel sums
  localparam int unsigned XW     = SampleWidth + 6;       // rounded magnitude
  localparam int unsigned RecipW = XW - 5;                // reciprocal of 35
  localparam int unsigned QW     = RecipW;                // quotient
  localparam int unsigned PW     = XW + RecipW;           // reciprocal product
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << XW) / Div);
  localparam logic [QW:0]       PosLim = (QW+1)'(2 ** (SampleWidth - 1) - 1);
  localparam logic [QW:0]       NegLim = (QW+1)'(2 ** (SampleWidth - 1));

  // Kernel for a given step of a job
  function automatic kern_e kern_of(plan_e plan, logic [CntW-1:0] step);
    kern_e k;
    k = KMid;
    case (plan)
      PlanShort: k = KPass;
      PlanStart, PlanStartEnd: begin
        case (step)
          CntW'(0): k = KFirst;
          CntW'(1): k = KSecond;
          CntW'(2): k = KMid;
          CntW'(3): k = KPenult;
          default:  k = KFinal;
        endcase
      end
      PlanMid: k = KMid;
      PlanMidEnd: begin
        case (step)
          CntW'(0): k = KMid;
          CntW'(1): k = KPenult;
          default:  k = KFinal;
        endcase
      end
      default: k = KMid;
    endcase
    return k;
  endfunction

  function automatic coef_t coef_of(kern_e k, logic [CntW-1:0] step, logic [CntW-1:0] idx);
    coef_t c;
    c = '0;
    case (k)
      KFirst:  c = CoefFirst[idx];
      KSecond: c = CoefSecond[idx];
      KMid:    c = CoefMid[idx];
      KPenult: c = CoefPenult[idx];
      KFinal:  c = CoefFinal[idx];
      KPass:   c = (idx == step) ? CoefPass : '0;
      default: c = '0;
    endcase
    return c;
  endfunction

  logic            adv, fire, final_step;
  kern_e           kern;
  logic [CntW-1:0] step_q, step_d;

  // Stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Stage payloads
  logic signed [SumW-1:0] prod_q [WinLen];
  logic                   div70_1_q, last_1_q;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic                   div70_2_q, last_2_q;
  logic [XW-1:0]          x3_q, x3_d;
  logic                   neg_3_q, last_3_q;
  logic [XW-1:0]          x4_q;
  logic [QW-1:0]          q0_q;
  logic                   neg_4_q, last_4_q;
  out_word_t              out_q, out_d;

  logic [SumW-1:0]        mag;
  logic [SumW-1:0]        xfull;
  logic [PW-1:0]          recip_prod;
  logic [XW-1:0]          m35, rem;
  logic [QW:0]            quo, quo_neg;

  // Whole pipeline moves when the output slot is free or being taken
  assign adv = !v5_q || out_ready_i;

  // Step sequencer over the head job
  assign kern        = kern_of(job_i.plan, step_q);
  assign final_step  = step_q == (job_i.nres - 1'b1);
  assign fire        = job_valid_i && adv;
  assign job_ready_o = adv && final_step;

  always_comb begin
    step_d = step_q;
    if (fire) begin
      step_d = final_step ? '0 : step_q + 1'b1;
    end
  end

  // Stage 1: coefficient products, one lane per tap
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < WinLen; i++) begin
        prod_q[i] <= SumW'(coef_of(kern, step_q, CntW'(i))) * SumW'(job_i.win[i]);
      end
      div70_1_q <= (kern == KFirst) || (kern == KFinal);
      last_1_q  <= job_i.last && final_step;
    end
  end

  // Stage 2: kernel sum
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < WinLen; i++) begin
      sum_d = sum_d + prod_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q     <= sum_d;
      div70_2_q <= div70_1_q;
      last_2_q  <= last_1_q;
    end
  end

  // Stage 3: magnitude with rounding offset; /70 folds into a halving then /35
  assign mag   = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign xfull = div70_2_q ? ((mag + SumW'(Div)) >> 1) : (mag + SumW'(HalfDiv));
  assign x3_d  = xfull[XW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x3_q     <= x3_d;
      neg_3_q  <= sum_q[SumW-1];
      last_3_q <= last_2_q;
    end
  end

  // Stage 4: quotient estimate by reciprocal, low by at most one
  assign recip_prod = PW'(x3_q) * PW'(Recip);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q0_q     <= recip_prod[XW +: QW];
      x4_q     <= x3_q;
      neg_4_q  <= neg_3_q;
      last_4_q <= last_3_q;
    end
  end

  // Stage 5: correct the estimate, apply sign, saturate
  assign m35     = XW'(q0_q) * XW'(Div);
  assign rem     = x4_q - m35;
  assign quo     = (QW+1)'(q0_q) + (QW+1)'(rem >= XW'(Div));
  assign quo_neg = '0 - quo;

  always_comb begin
    out_d.last_result = last_4_q;
    if (neg_4_q) begin
      out_d.smoothed = (quo > NegLim) ? SampleMin : quo_neg[SampleWidth-1:0];
    end else begin
      out_d.smoothed = (quo > PosLim) ? SampleMax : quo[SampleWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
    end else begin
      step_q <= step_d;
      if (adv) begin
        v1_q <= fire;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
      end
    end
  end

  assign out_valid_o = v5_q;
  assign out_word_o  = out_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> job_valid_i)
    else $error("job left the queue head in the middle of its steps");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < CntW'(WinLen))
    else $error("step counter beyond window length");

endmodule
